[hw/rtl/lss_pkg.sv]
// lss_pkg: shared constants, request and status codes and control structs
// for the lifo stack with search and remove; no dependencies
`default_nettype none

package lss_pkg;

    localparam int DEPTH       = 8;
    localparam int KEY_WIDTH   = 64;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);

    localparam int KEY_IN_W    = 64;
    localparam int KEY_OUT_W   = 64;
    localparam int REQ_W       = 3;
    localparam int STATUS_W    = 2;
    localparam int OCC_W       = 4;

    localparam int IN_TDATA_W  = KEY_IN_W;
    localparam int IN_TUSER_W  = REQ_W;
    localparam int OUT_TDATA_W = ((KEY_OUT_W + OCC_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W = STATUS_W + 1;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH   = 3'd0,
        REQ_REMOVE = 3'd1,
        REQ_LIST   = 3'd2,
        REQ_COUNT  = 3'd3,
        REQ_SEARCH = 3'd4
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic capture;
        logic exec;
    } t_dp_cmd;

    typedef struct packed {
        logic req_known;
        logic req_list;
        logic fill_zero;
        logic list_more;
    } t_dp_stat;

endpackage

`default_nettype wire

[hw/rtl/lss_dp.sv]
// lss_dp: datapath with request register, entry file, parallel key compare,
// gap-closing shift, list index and result register; uses lss_pkg
`default_nettype none

module lss_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire lss_pkg::t_dp_cmd              i_cmd,
    output lss_pkg::t_dp_stat                  o_stat,
    input  wire logic [lss_pkg::REQ_W-1:0]     i_req,
    input  wire logic [lss_pkg::KEY_IN_W-1:0]  i_key,
    output logic [lss_pkg::STATUS_W-1:0]       o_status,
    output logic                               o_found,
    output logic [lss_pkg::KEY_OUT_W-1:0]      o_key_out,
    output logic [lss_pkg::OCC_W-1:0]          o_occupancy,
    output logic                               o_last
);
    import lss_pkg::*;

    t_req                 r_req;
    logic [KEY_WIDTH-1:0] r_key;
    logic [KEY_WIDTH-1:0] r_entries [DEPTH];
    logic [KEY_WIDTH-1:0] n_entries [DEPTH];
    logic [CNT_W-1:0]     r_fill, n_fill;
    logic [IDX_W-1:0]     r_idx, n_idx;

    t_status              r_status, n_status;
    logic                 r_found, n_found;
    logic [KEY_WIDTH-1:0] r_key_out, n_key_out;
    logic                 r_last, n_last;

    logic [DEPTH-1:0]     v_match;
    logic                 v_any;
    logic [IDX_W-1:0]     v_pos;
    logic [CNT_W-1:0]     v_rd_full;
    logic [IDX_W-1:0]     v_rd;
    logic                 v_full;
    logic                 v_empty;
    logic                 v_more;

    // parallel compare over the stored entries, topmost match wins
    always_comb begin
        v_any = 1'b0;
        v_pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            v_match[i] = (r_entries[i] == r_key) && (CNT_W'(i) < r_fill);
        end
        for (int i = 0; i < DEPTH; i++) begin
            if (v_match[i]) begin
                v_any = 1'b1;
                v_pos = IDX_W'(i);
            end
        end
    end

    assign v_full    = (r_fill == CNT_W'(DEPTH));
    assign v_empty   = (r_fill == '0);
    assign v_rd_full = r_fill - CNT_W'(1) - CNT_W'(r_idx);
    assign v_rd      = v_rd_full[IDX_W-1:0];
    assign v_more    = ((CNT_W'(r_idx) + CNT_W'(1)) != r_fill);

    always_comb begin
        n_entries = r_entries;
        n_fill    = r_fill;
        n_idx     = r_idx;
        n_status  = r_status;
        n_found   = r_found;
        n_key_out = r_key_out;
        n_last    = r_last;
        if (i_cmd.capture) begin
            n_idx = '0;
        end else if (i_cmd.exec) begin
            n_status  = ST_OK;
            n_found   = 1'b0;
            n_key_out = '0;
            n_last    = 1'b1;
            case (r_req)
                REQ_PUSH: begin
                    if (v_full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_entries[r_fill[IDX_W-1:0]] = r_key;
                        n_fill = r_fill + CNT_W'(1);
                    end
                end
                REQ_REMOVE: begin
                    if (v_empty) begin
                        n_status = ST_EMPTY;
                    end else if (!v_any) begin
                        n_status = ST_NOT_FOUND;
                    end else begin
                        // close the gap above the removed entry
                        for (int i = 0; i < DEPTH - 1; i++) begin
                            if ((IDX_W'(i) >= v_pos) &&
                                ((CNT_W'(i) + CNT_W'(1)) < r_fill)) begin
                                n_entries[i] = r_entries[i+1];
                            end
                        end
                        n_fill    = r_fill - CNT_W'(1);
                        n_found   = 1'b1;
                        n_key_out = r_key;
                    end
                end
                REQ_LIST: begin
                    if (v_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_key_out = r_entries[v_rd];
                        n_last    = !v_more;
                        n_idx     = r_idx + IDX_W'(1);
                    end
                end
                REQ_COUNT: begin
                    n_status = ST_OK;
                end
                REQ_SEARCH: begin
                    if (v_any) begin
                        n_found = 1'b1;
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                end
                default: begin
                    n_status = r_status;
                    n_found  = r_found;
                    n_key_out = r_key_out;
                    n_last   = r_last;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_idx  <= '0;
        end else begin
            r_fill <= n_fill;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= t_req'(i_req);
            r_key <= i_key[KEY_WIDTH-1:0];
        end
        r_entries <= n_entries;
        r_status  <= n_status;
        r_found   <= n_found;
        r_key_out <= n_key_out;
        r_last    <= n_last;
    end

    always_comb begin
        o_stat.req_known = (r_req == REQ_PUSH) || (r_req == REQ_REMOVE) ||
                           (r_req == REQ_LIST) || (r_req == REQ_COUNT) ||
                           (r_req == REQ_SEARCH);
        o_stat.req_list  = (r_req == REQ_LIST);
        o_stat.fill_zero = v_empty;
        o_stat.list_more = v_more;
    end

    assign o_status    = r_status;
    assign o_found     = r_found;
    assign o_key_out   = KEY_OUT_W'(r_key_out);
    assign o_occupancy = OCC_W'(r_fill);
    assign o_last      = r_last;

endmodule

`default_nettype wire

[hw/rtl/lss_ctrl.sv]
// lss_ctrl: controller state machine for request capture, execution,
// list stepping and the result valid flag; uses lss_pkg
`default_nettype none

module lss_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output lss_pkg::t_dp_cmd       o_cmd,
    input  wire lss_pkg::t_dp_stat i_stat
);
    import lss_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_LIST = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   v_out_free;
    logic   v_load;

    assign v_out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state       = r_state;
        v_load        = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.exec    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!i_stat.req_known) begin
                    n_state = S_IDLE;
                end else if (v_out_free) begin
                    o_cmd.exec = 1'b1;
                    v_load     = 1'b1;
                    if (i_stat.req_list && !i_stat.fill_zero && i_stat.list_more) begin
                        n_state = S_LIST;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_LIST: begin
                if (v_out_free) begin
                    o_cmd.exec = 1'b1;
                    v_load     = 1'b1;
                    if (!i_stat.list_more) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_m_tready;
        if (v_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

endmodule

`default_nettype wire

[hw/rtl/lifo_stack_with_search_and_remove.sv]
// lifo_stack_with_search_and_remove: top level joining lss_ctrl and lss_dp
// behind stream ports; uses lss_pkg
//
//  channel | dir | tdata (low bit up)                | tuser (low bit up)     | tlast
//  s       | in  | key[63:0]                         | req_type[2:0]          | -
//  m       | out | key_out[63:0], occupancy[67:64],  | status[1:0], found[2]  | last
//          |     | zero[71:68]                       |                        |
//
// a request is captured in S_IDLE and executed in S_EXEC once the output
// register is free, unknown types give no result; one request at a time
// a list request on a non-empty stack emits one entry per cycle while the
// output register is free, fill_level entries in all, topmost first
// reset clears the fill level and the controller; entries need no clearing
// a stalled result holds in the output register; a new request is taken
// while it waits, and execution waits until the register frees
`default_nettype none

module lifo_stack_with_search_and_remove (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [lss_pkg::IN_TDATA_W-1:0]   s_tdata,   // key
    input  wire logic [lss_pkg::IN_TUSER_W-1:0]   s_tuser,   // req_type
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [lss_pkg::OUT_TDATA_W-1:0]       m_tdata,   // key_out, occupancy, zero
    output logic [lss_pkg::OUT_TUSER_W-1:0]       m_tuser,   // status, found
    output logic                                  m_tlast
);
    import lss_pkg::*;

    t_dp_cmd               w_cmd;
    t_dp_stat              w_stat;
    logic [STATUS_W-1:0]   w_status;
    logic                  w_found;
    logic [KEY_OUT_W-1:0]  w_key_out;
    logic [OCC_W-1:0]      w_occ;

    lss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    lss_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_req       (s_tuser),
        .i_key       (s_tdata),
        .o_status    (w_status),
        .o_found     (w_found),
        .o_key_out   (w_key_out),
        .o_occupancy (w_occ),
        .o_last      (m_tlast)
    );

    assign m_tdata = OUT_TDATA_W'({w_occ, w_key_out});
    assign m_tuser = {w_found, w_status};

endmodule

`default_nettype wire
